[design/bsae_pkg.sv]
package bsae_pkg;

	// Operation codes carried in the input tuser field.
	localparam logic [2:0] OP_CLEAR     = 3'd0;
	localparam logic [2:0] OP_INSERT_A  = 3'd1;
	localparam logic [2:0] OP_INSERT_B  = 3'd2;
	localparam logic [2:0] OP_MEMBER    = 3'd3;
	localparam logic [2:0] OP_SEARCH    = 3'd4;
	localparam logic [2:0] OP_RELATIONS = 3'd5;

	// Set expression selectors.
	localparam logic [2:0] EXPR_A       = 3'd0;
	localparam logic [2:0] EXPR_B       = 3'd1;
	localparam logic [2:0] EXPR_UNION   = 3'd2;
	localparam logic [2:0] EXPR_INTER   = 3'd3;
	localparam logic [2:0] EXPR_A_NOT_B = 3'd4;
	localparam logic [2:0] EXPR_B_NOT_A = 3'd5;
	localparam logic [2:0] EXPR_NOT_A   = 3'd6;
	localparam logic [2:0] EXPR_NOT_B   = 3'd7;

	// Result status codes.
	localparam logic [1:0] STATUS_OK    = 2'd0;
	localparam logic [1:0] STATUS_DUP   = 2'd1;
	localparam logic [1:0] STATUS_RANGE = 2'd2;
	localparam logic [1:0] STATUS_NONE  = 2'd3;

	// Classification of one universe position.
	typedef struct packed {
		logic hit;
		logic only_a;
		logic only_b;
		logic both;
	} point_t;

endpackage

[design/bsae_point.sv]
module bsae_point
	import bsae_pkg::*;
(
	input  logic       a_bit,
	input  logic       b_bit,
	input  logic [2:0] expr,
	output point_t     pt
);

	always_comb begin
		pt.only_a = a_bit & ~b_bit;
		pt.only_b = b_bit & ~a_bit;
		pt.both   = a_bit & b_bit;
		unique case (expr)
			EXPR_A:       pt.hit = a_bit;
			EXPR_B:       pt.hit = b_bit;
			EXPR_UNION:   pt.hit = a_bit | b_bit;
			EXPR_INTER:   pt.hit = a_bit & b_bit;
			EXPR_A_NOT_B: pt.hit = a_bit & ~b_bit;
			EXPR_B_NOT_A: pt.hit = b_bit & ~a_bit;
			EXPR_NOT_A:   pt.hit = ~a_bit;
			EXPR_NOT_B:   pt.hit = ~b_bit;
		endcase
	end

endmodule

[design/bounded_set_algebra_engine.sv]
// Two sets A and B over a universe of UNIVERSE_SIZE integers centered on zero
// (-49..49 by default) are kept in one membership store, one word per universe
// position, together with member counts. Each input transfer carries one operation:
// clear, insert into A, insert into B, membership test, nearest-member search over a
// set expression, or relations report; each yields exactly one output transfer. A
// single position classifier is stepped over the store by a small sequencer, one
// universe position per cycle behind a registered read. An insert, a membership test or
// an unused operation code passes through the fetch, scan and done states. A search
// scans positions in the search direction until a hit or the end of the universe; a
// cursor beyond the universe in the search direction is settled on its first scan step.
// A relations report scans every position, and a clear writes every position once.
// After reset the store is cleared the same way before the block first becomes ready.
// The block is not ready for a new item until the previous result has moved into the
// output register, which may then wait for the downstream side.
module bounded_set_algebra_engine
	import bsae_pkg::*;
#(
	parameter int UNIVERSE_SIZE = 99
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	// [7:0] value, [10:8] set_expression, [11] search_down, [15:12] zero
	input  logic [15:0] s_tdata,
	// [2:0] operation
	input  logic [2:0]  s_tuser,
	output logic        m_tvalid,
	input  logic        m_tready,
	// [6:0] found_value, [7] in_first, [8] in_second, [9] sets_equal,
	// [10] first_within_second, [11] second_within_first, [12] sets_disjoint,
	// [19:13] size_first, [26:20] size_second, [31:27] zero
	output logic [31:0] m_tdata,
	// [1:0] status
	output logic [1:0]  m_tuser
);

	localparam int PW = (UNIVERSE_SIZE > 1) ? $clog2(UNIVERSE_SIZE) : 1;
	localparam int CW = $clog2(UNIVERSE_SIZE + 1);
	localparam int UnivLow = -((UNIVERSE_SIZE - 1) / 2);
	localparam int UnivHigh = UnivLow + UNIVERSE_SIZE - 1;
	localparam logic signed [9:0] LowS = 10'(UnivLow);
	localparam logic signed [9:0] HighS = 10'(UnivHigh);
	localparam logic [PW-1:0] LastIdx = PW'(UNIVERSE_SIZE - 1);

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_FETCH,
		ST_SCAN,
		ST_DONE
	} state_t;

	state_t state_q;
	logic   boot_q;

	// Bit 0 holds membership in A, bit 1 membership in B.
	logic [1:0]    members_q [UNIVERSE_SIZE];
	logic [1:0]    rd_q;
	logic          mem_we;
	logic [PW-1:0] mem_waddr;
	logic [1:0]    mem_wdata;

	logic [CW-1:0] count_a_q;
	logic [CW-1:0] count_b_q;

	logic [2:0]    op_q;
	logic [2:0]    expr_q;
	logic          down_q;
	logic          in_range_q;
	logic          none_q;
	logic [PW-1:0] idx_q;
	logic [PW-1:0] pos_q;

	logic [1:0] status_q;
	logic [6:0] found_q;
	logic       in_a_q;
	logic       in_b_q;
	logic       eq_q;
	logic       a_in_b_q;
	logic       b_in_a_q;
	logic       disj_q;

	logic        m_tvalid_q;
	logic [31:0] m_tdata_q;
	logic [1:0]  m_tuser_q;

	// Decode of the incoming value against the universe bounds.
	logic signed [9:0] in_value;
	logic signed [9:0] in_offset;
	logic              in_below;
	logic              in_above;
	logic              in_down;
	logic [PW-1:0]     in_start;

	assign in_value  = 10'(signed'(s_tdata[7:0]));
	assign in_offset = in_value - LowS;
	assign in_below  = in_value < LowS;
	assign in_above  = in_value > HighS;
	assign in_down   = s_tdata[11];

	// Values outside the universe still point the read at a valid position.
	always_comb begin
		priority if (in_down && in_above) begin
			in_start = LastIdx;
		end else if (in_below || in_above) begin
			in_start = '0;
		end else begin
			in_start = in_offset[PW-1:0];
		end
	end

	point_t pt;

	bsae_point u_point (
		.a_bit (rd_q[0]),
		.b_bit (rd_q[1]),
		.expr  (expr_q),
		.pt    (pt)
	);

	logic              at_end;
	logic [PW-1:0]     idx_next;
	logic signed [9:0] pos_value;
	logic              out_load;

	assign at_end    = down_q ? (pos_q == '0) : (pos_q == LastIdx);
	assign pos_value = signed'(10'(pos_q)) + LowS;
	assign out_load  = (state_q == ST_DONE) && (!m_tvalid_q || m_tready);

	always_comb begin
		if (down_q) begin
			idx_next = (idx_q == '0) ? idx_q : idx_q - 1'b1;
		end else begin
			idx_next = (idx_q == LastIdx) ? idx_q : idx_q + 1'b1;
		end
	end

	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = pos_q;
		mem_wdata = rd_q;
		if (state_q == ST_CLEAR) begin
			mem_we    = 1'b1;
			mem_waddr = idx_q;
			mem_wdata = '0;
		end else if (state_q == ST_SCAN && in_range_q) begin
			if (op_q == OP_INSERT_A && !rd_q[0]) begin
				mem_we    = 1'b1;
				mem_wdata = {rd_q[1], 1'b1};
			end else if (op_q == OP_INSERT_B && !rd_q[1]) begin
				mem_we    = 1'b1;
				mem_wdata = {1'b1, rd_q[0]};
			end
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			members_q[mem_waddr] <= mem_wdata;
		end
		rd_q <= members_q[idx_q];
	end

	assign s_tready = (state_q == ST_IDLE);
	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tuser  = m_tuser_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			boot_q      <= 1'b1;
			count_a_q   <= '0;
			count_b_q   <= '0;
			op_q        <= OP_CLEAR;
			expr_q      <= EXPR_A;
			down_q      <= 1'b0;
			in_range_q  <= 1'b0;
			none_q      <= 1'b0;
			idx_q       <= '0;
			pos_q       <= '0;
			status_q    <= STATUS_OK;
			found_q     <= '0;
			in_a_q      <= 1'b0;
			in_b_q      <= 1'b0;
			eq_q        <= 1'b0;
			a_in_b_q    <= 1'b0;
			b_in_a_q    <= 1'b0;
			disj_q      <= 1'b0;
			m_tvalid_q  <= 1'b0;
			m_tdata_q   <= '0;
			m_tuser_q   <= STATUS_OK;
		end else begin
			if (out_load) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end

			unique case (state_q)
				ST_CLEAR: begin
					count_a_q <= '0;
					count_b_q <= '0;
					if (idx_q == LastIdx) begin
						boot_q  <= 1'b0;
						state_q <= boot_q ? ST_IDLE : ST_DONE;
					end else begin
						idx_q <= idx_q + 1'b1;
					end
				end

				ST_IDLE: begin
					if (s_tvalid) begin
						op_q       <= s_tuser;
						expr_q     <= s_tdata[10:8];
						down_q     <= in_down && (s_tuser == OP_SEARCH);
						in_range_q <= !in_below && !in_above;
						none_q     <= in_down ? in_below : in_above;
						// Relations and clear start from the lowest position.
						idx_q      <= (s_tuser == OP_RELATIONS || s_tuser == OP_CLEAR) ?
						              '0 : in_start;
						status_q   <= STATUS_OK;
						found_q    <= '0;
						in_a_q     <= 1'b0;
						in_b_q     <= 1'b0;
						eq_q       <= (s_tuser == OP_RELATIONS);
						a_in_b_q   <= (s_tuser == OP_RELATIONS);
						b_in_a_q   <= (s_tuser == OP_RELATIONS);
						disj_q     <= (s_tuser == OP_RELATIONS);
						state_q    <= (s_tuser == OP_CLEAR) ? ST_CLEAR : ST_FETCH;
					end
				end

				ST_FETCH: begin
					// The read register now takes the word of the first position,
					// and the address runs one position ahead of it from here on.
					pos_q   <= idx_q;
					idx_q   <= idx_next;
					state_q <= ST_SCAN;
				end

				ST_SCAN: begin
					unique case (op_q)
						OP_INSERT_A: begin
							priority if (!in_range_q) begin
								status_q <= STATUS_RANGE;
							end else if (rd_q[0]) begin
								status_q <= STATUS_DUP;
							end else begin
								count_a_q <= count_a_q + 1'b1;
							end
							state_q <= ST_DONE;
						end
						OP_INSERT_B: begin
							priority if (!in_range_q) begin
								status_q <= STATUS_RANGE;
							end else if (rd_q[1]) begin
								status_q <= STATUS_DUP;
							end else begin
								count_b_q <= count_b_q + 1'b1;
							end
							state_q <= ST_DONE;
						end
						OP_MEMBER: begin
							if (!in_range_q) begin
								status_q <= STATUS_RANGE;
							end else begin
								in_a_q <= rd_q[0];
								in_b_q <= rd_q[1];
							end
							state_q <= ST_DONE;
						end
						OP_SEARCH: begin
							priority if (none_q) begin
								status_q <= STATUS_NONE;
								state_q  <= ST_DONE;
							end else if (pt.hit) begin
								status_q <= STATUS_OK;
								found_q  <= pos_value[6:0];
								state_q  <= ST_DONE;
							end else if (at_end) begin
								status_q <= STATUS_NONE;
								state_q  <= ST_DONE;
							end else begin
								pos_q <= idx_q;
								idx_q <= idx_next;
							end
						end
						OP_RELATIONS: begin
							eq_q     <= eq_q & ~pt.only_a & ~pt.only_b;
							a_in_b_q <= a_in_b_q & ~pt.only_a;
							b_in_a_q <= b_in_a_q & ~pt.only_b;
							disj_q   <= disj_q & ~pt.both;
							if (pos_q == LastIdx) begin
								state_q <= ST_DONE;
							end else begin
								pos_q <= idx_q;
								idx_q <= idx_next;
							end
						end
						default: begin
							state_q <= ST_DONE;
						end
					endcase
				end

				ST_DONE: begin
					// The result moves out once the output register is free.
					if (out_load) begin
						m_tuser_q  <= status_q;
						m_tdata_q  <= {5'b0, 7'(count_b_q), 7'(count_a_q), disj_q,
						               b_in_a_q, a_in_b_q, eq_q, in_b_q, in_a_q, found_q};
						state_q    <= ST_IDLE;
					end
				end

				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule
